### rtl/core/gff_rlf_pkg.sv
// package with shared constants for the region line finder
package gff_rlf_pkg;

   localparam int MAX_ID_BYTES_DEFAULT = 8;
   localparam int LINE_BITS_DEFAULT    = 32;

   localparam int ID_WIDTH     = 64;
   localparam int ID_LEN_WIDTH = 4;
   localparam int POS_WIDTH    = 4;
   localparam int OUT_LINE_WIDTH = 32;

   // csr register indexes
   localparam logic CSR_ID_BYTES  = 1'b0;
   localparam logic CSR_ID_LENGTH = 1'b1;

   // scanner phases
   typedef logic [1:0] phase_type;
   localparam phase_type PH_HEADER = 2'd0;
   localparam phase_type PH_FIELD  = 2'd1;
   localparam phase_type PH_REST   = 2'd2;
   localparam phase_type PH_DONE   = 2'd3;

   // characters of interest
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_NL   = 8'h0A;

endpackage

### rtl/core/gff_region_line_finder.sv
// top level of the region line finder: byte scanner, scan state and result register
//
// usage
//  - req channel: one text byte per transaction (req_data_byte) plus req_is_last,
//    which marks the final byte of a stream; a transaction is taken on a rising
//    edge with req_valid high and req_stall low
//  - rsp channel: one transaction per stream, produced by the byte that carries
//    req_is_last; it reports rsp_found and the first and last line index of the
//    matching run (all zero when nothing matched)
//  - csr port: index 0 writes the identifier bytes (first character in bits 7:0),
//    index 1 writes the identifier length; write only while the block is idle
//  - latency: the response is visible in the cycle after the last byte is taken
//  - throughput: one byte per cycle while req_stall is low; each byte runs through
//    character compares and counter and flag updates between the scan state registers
//    and the response register
//  - stall: while a response waits under rsp_stall the block raises req_stall,
//    as soon as the response drains the next byte is taken in the same cycle
//  - reset: synchronous, clears the scan state, the response register and the
//    csr values (identifier bytes zero, length one)
//  - after each last byte the scan state returns to its reset values so the
//    next byte starts a new stream; csr values are kept
module gff_region_line_finder #(
   parameter int MAX_ID_BYTES = gff_rlf_pkg::MAX_ID_BYTES_DEFAULT,
   parameter int LINE_BITS    = gff_rlf_pkg::LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   // csr write port
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,

   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,

   // result out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_first_line,
   output logic [31:0] rsp_last_line
);

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // csr registers
   logic [gff_rlf_pkg::ID_WIDTH-1:0]     id_bytes_ff;
   logic [gff_rlf_pkg::ID_LEN_WIDTH-1:0] id_length_ff;

   // scan state
   gff_rlf_pkg::phase_type             phase_ff, phase_in;
   logic [LINE_BITS-1:0]               line_index_ff, line_index_in;
   logic [gff_rlf_pkg::POS_WIDTH-1:0]  field_pos_ff, field_pos_in;
   logic                               mismatch_ff, mismatch_in;
   logic                               region_found_ff, region_found_in;
   logic [LINE_BITS-1:0]               region_start_ff, region_start_in;
   logic [LINE_BITS-1:0]               region_end_ff, region_end_in;

   // response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [31:0]                        rsp_first_ff, rsp_first_in;
   logic [31:0]                        rsp_last_ff, rsp_last_in;

   logic                               req_take;
   logic [gff_rlf_pkg::ID_LEN_WIDTH-1:0] eff_length;
   logic [7:0]                         want_byte;
   logic                               field_match;
   logic [LINE_BITS-1:0]               line_prev;
   logic [LINE_BITS-1:0]               line_next;

   // a held response blocks new bytes only while it is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // identifier length clamped to the supported maximum
   assign eff_length = (id_length_ff > gff_rlf_pkg::ID_LEN_WIDTH'(MAX_ID_BYTES))
                       ? gff_rlf_pkg::ID_LEN_WIDTH'(MAX_ID_BYTES) : id_length_ff;

   // identifier character at the current field position (only used when pos < length)
   assign want_byte   = id_bytes_ff[{field_pos_ff[2:0], 3'b000} +: 8];
   assign field_match = ~mismatch_ff & (field_pos_ff == eff_length);
   assign line_prev   = line_index_ff - LINE_BITS'(1);
   assign line_next   = (line_index_ff != LINE_MAX) ? line_index_ff + LINE_BITS'(1)
                                                    : line_index_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         id_bytes_ff  <= '0;
         id_length_ff <= gff_rlf_pkg::ID_LEN_WIDTH'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gff_rlf_pkg::CSR_ID_BYTES:  id_bytes_ff  <= csr_wdata;
            gff_rlf_pkg::CSR_ID_LENGTH: id_length_ff <= csr_wdata[gff_rlf_pkg::ID_LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // byte scanner: next scan state and response contents
   always_comb begin
      phase_in        = phase_ff;
      line_index_in   = line_index_ff;
      field_pos_in    = field_pos_ff;
      mismatch_in     = mismatch_ff;
      region_found_in = region_found_ff;
      region_start_in = region_start_ff;
      region_end_in   = region_end_ff;

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_take) begin
         unique case (phase_ff)
            gff_rlf_pkg::PH_HEADER,
            gff_rlf_pkg::PH_REST: begin
               if (req_data_byte == gff_rlf_pkg::CH_NL) begin
                  line_index_in = line_next;
                  phase_in      = gff_rlf_pkg::PH_FIELD;
                  field_pos_in  = '0;
                  mismatch_in   = 1'b0;
               end
            end
            gff_rlf_pkg::PH_FIELD: begin
               priority if (req_data_byte == gff_rlf_pkg::CH_HASH) begin
                  // comment line, skip the rest
                  phase_in = gff_rlf_pkg::PH_REST;
               end else if (req_data_byte == gff_rlf_pkg::CH_NL) begin
                  // line without a tab is skipped
                  line_index_in = line_next;
                  field_pos_in  = '0;
                  mismatch_in   = 1'b0;
               end else if (req_data_byte == gff_rlf_pkg::CH_TAB) begin
                  // end of first field: open or close the run
                  phase_in = gff_rlf_pkg::PH_REST;
                  if (!region_found_ff) begin
                     if (field_match) begin
                        region_found_in = 1'b1;
                        region_start_in = line_index_ff;
                     end
                  end else if (!field_match) begin
                     region_end_in = line_prev;
                     phase_in      = gff_rlf_pkg::PH_DONE;
                  end
               end else begin
                  if (field_pos_ff >= eff_length || want_byte != req_data_byte) begin
                     mismatch_in = 1'b1;
                  end
                  if (field_pos_ff != '1) begin
                     field_pos_in = field_pos_ff + gff_rlf_pkg::POS_WIDTH'(1);
                  end
               end
            end
            default: ;   // run closed, ignore rest of stream
         endcase

         if (req_is_last) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = region_found_in;
            if (region_found_in) begin
               rsp_first_in = 32'(region_start_in);
               // open run ends at the line before, or at the current line after its tab
               unique case (phase_in)
                  gff_rlf_pkg::PH_FIELD: rsp_last_in = 32'(line_index_in - LINE_BITS'(1));
                  gff_rlf_pkg::PH_REST:  rsp_last_in = 32'(line_index_in);
                  default:               rsp_last_in = 32'(region_end_in);
               endcase
            end else begin
               rsp_first_in = '0;
               rsp_last_in  = '0;
            end

            // new stream starts with the next byte
            phase_in        = gff_rlf_pkg::PH_HEADER;
            line_index_in   = '0;
            field_pos_in    = '0;
            mismatch_in     = 1'b0;
            region_found_in = 1'b0;
            region_start_in = '0;
            region_end_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= gff_rlf_pkg::PH_HEADER;
         line_index_ff   <= '0;
         field_pos_ff    <= '0;
         mismatch_ff     <= 1'b0;
         region_found_ff <= 1'b0;
         region_start_ff <= '0;
         region_end_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         line_index_ff   <= line_index_in;
         field_pos_ff    <= field_pos_in;
         mismatch_ff     <= mismatch_in;
         region_found_ff <= region_found_in;
         region_start_ff <= region_start_in;
         region_end_ff   <= region_end_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_found_ff <= 1'b0;
         rsp_first_ff <= '0;
         rsp_last_ff  <= '0;
      end else begin
         rsp_found_ff <= rsp_found_in;
         rsp_first_ff <= rsp_first_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_first_line = rsp_first_ff;
   assign rsp_last_line  = rsp_last_ff;

endmodule
